@@ rtl/core/vdq_pkg.sv @@
// shared types and constants for the vector direction quantizer
// used by every module under rtl/core; no dependencies

package vdq_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned DIR_W   = 4;
    localparam int unsigned DIV_W   = COORD_W - 4;   // major / 16
    localparam int unsigned MUL_W   = COORD_W;       // 12 * (major / 16) fits in coord width

    // distance at or under which a vector counts as lying on an axis
    localparam logic [COORD_W-1:0] NEAR_LIMIT = COORD_W'(31);

    // quotient thresholds where the octant offset steps up (0, 1, 2)
    localparam logic [3:0] STEP_ONE = 4'd4;
    localparam logic [3:0] STEP_TWO = 4'd12;

    // sector codes, clockwise from right
    localparam logic [DIR_W-1:0] DIR_RIGHT = 4'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 4'd4;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 4'd8;
    localparam logic [DIR_W-1:0] DIR_UP    = 4'd12;

    // first stage: magnitudes, sign flags and near-axis flags
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic               dx_pos;
        logic               dy_pos;
        logic               near_x;
        logic               near_y;
    } t_delta;

    // second stage: minor axis, division operands folded into compare thresholds, octant base and flags
    typedef struct packed {
        logic [COORD_W-1:0] minor;
        logic [MUL_W-1:0]   lim_one;   // STEP_ONE * div
        logic [MUL_W-1:0]   lim_two;   // STEP_TWO * div
        logic [DIR_W-1:0]   base;
        logic               neg;       // offset is subtracted from base
        logic               axial;     // offset forced to zero
    } t_ratio;

endpackage

@@ rtl/core/vdq_delta.sv @@
// stage one: coordinate differences, magnitudes and axis tests
// depends on vdq_pkg

module vdq_delta (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [vdq_pkg::COORD_W-1:0]  i_from_x,
    input  logic [vdq_pkg::COORD_W-1:0]  i_from_y,
    input  logic [vdq_pkg::COORD_W-1:0]  i_to_x,
    input  logic [vdq_pkg::COORD_W-1:0]  i_to_y,
    output logic                         o_valid,
    output vdq_pkg::t_delta              o_delta
);

    logic signed [vdq_pkg::COORD_W:0] dx;
    logic signed [vdq_pkg::COORD_W:0] dy;
    logic [vdq_pkg::COORD_W:0]        abs_x;
    logic [vdq_pkg::COORD_W:0]        abs_y;
    vdq_pkg::t_delta                  n_delta;
    vdq_pkg::t_delta                  r_delta;
    logic                             r_valid;

    always_comb begin
        dx    = $signed({1'b0, i_to_x}) - $signed({1'b0, i_from_x});
        dy    = $signed({1'b0, i_to_y}) - $signed({1'b0, i_from_y});
        abs_x = dx[vdq_pkg::COORD_W] ? 11'(-dx) : 11'(dx);
        abs_y = dy[vdq_pkg::COORD_W] ? 11'(-dy) : 11'(dy);
        n_delta.ax     = abs_x[vdq_pkg::COORD_W-1:0];
        n_delta.ay     = abs_y[vdq_pkg::COORD_W-1:0];
        n_delta.dx_pos = (dx > 0);
        n_delta.dy_pos = (dy > 0);
        n_delta.near_x = (abs_x[vdq_pkg::COORD_W-1:0] <= vdq_pkg::NEAR_LIMIT);
        n_delta.near_y = (abs_y[vdq_pkg::COORD_W-1:0] <= vdq_pkg::NEAR_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_delta <= n_delta;
    end

    assign o_valid = r_valid;
    assign o_delta = r_delta;

endmodule

@@ rtl/core/vdq_octant.sv @@
// stage two: picks the octant, the major and minor axis, and the division thresholds
// depends on vdq_pkg

module vdq_octant (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  vdq_pkg::t_delta  i_delta,
    output logic             o_valid,
    output vdq_pkg::t_ratio  o_ratio
);

    logic                           y_major;
    logic [vdq_pkg::COORD_W-1:0]    major;
    logic [vdq_pkg::DIV_W-1:0]      div;
    vdq_pkg::t_ratio                n_ratio;
    vdq_pkg::t_ratio                r_ratio;
    logic                           r_valid;

    always_comb begin
        y_major = (i_delta.ay > i_delta.ax);
        major   = y_major ? i_delta.ay : i_delta.ax;
        div     = major[vdq_pkg::COORD_W-1:4];

        n_ratio.minor   = y_major ? i_delta.ax : i_delta.ay;
        // q = minor / div reaches a threshold k exactly when minor >= k * div
        n_ratio.lim_one = vdq_pkg::MUL_W'(div) * vdq_pkg::MUL_W'(vdq_pkg::STEP_ONE);
        n_ratio.lim_two = vdq_pkg::MUL_W'(div) * vdq_pkg::MUL_W'(vdq_pkg::STEP_TWO);
        n_ratio.axial   = 1'b0;
        n_ratio.neg     = 1'b0;
        n_ratio.base    = vdq_pkg::DIR_RIGHT;

        priority if (i_delta.near_x) begin
            n_ratio.axial = 1'b1;
            n_ratio.base  = i_delta.dy_pos ? vdq_pkg::DIR_DOWN : vdq_pkg::DIR_UP;
        end else if (i_delta.near_y) begin
            n_ratio.axial = 1'b1;
            n_ratio.base  = i_delta.dx_pos ? vdq_pkg::DIR_RIGHT : vdq_pkg::DIR_LEFT;
        end else begin
            unique case ({i_delta.dx_pos, i_delta.dy_pos, y_major})
                3'b000: begin n_ratio.base = vdq_pkg::DIR_LEFT;  n_ratio.neg = 1'b0; end
                3'b001: begin n_ratio.base = vdq_pkg::DIR_UP;    n_ratio.neg = 1'b1; end
                3'b010: begin n_ratio.base = vdq_pkg::DIR_LEFT;  n_ratio.neg = 1'b1; end
                3'b011: begin n_ratio.base = vdq_pkg::DIR_DOWN;  n_ratio.neg = 1'b0; end
                3'b100: begin n_ratio.base = vdq_pkg::DIR_RIGHT; n_ratio.neg = 1'b1; end
                3'b101: begin n_ratio.base = vdq_pkg::DIR_UP;    n_ratio.neg = 1'b0; end
                3'b110: begin n_ratio.base = vdq_pkg::DIR_RIGHT; n_ratio.neg = 1'b0; end
                default: begin n_ratio.base = vdq_pkg::DIR_DOWN; n_ratio.neg = 1'b1; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_ratio <= n_ratio;
    end

    assign o_valid = r_valid;
    assign o_ratio = r_ratio;

endmodule

@@ rtl/core/vdq_sector.sv @@
// stage three: quotient class from threshold compares, offset applied to the octant base
// depends on vdq_pkg

module vdq_sector (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  vdq_pkg::t_ratio            i_ratio,
    output logic                       o_valid,
    output logic [vdq_pkg::DIR_W-1:0]  o_direction
);

    logic [1:0]                  offset;
    logic [vdq_pkg::DIR_W-1:0]   n_direction;
    logic [vdq_pkg::DIR_W-1:0]   r_direction;
    logic                        r_valid;

    always_comb begin
        // a quotient past the table end lands in the top class anyway
        priority if (i_ratio.axial) begin
            offset = 2'd0;
        end else if (i_ratio.minor >= i_ratio.lim_two) begin
            offset = 2'd2;
        end else if (i_ratio.minor >= i_ratio.lim_one) begin
            offset = 2'd1;
        end else begin
            offset = 2'd0;
        end
        // sectors wrap modulo 16
        n_direction = i_ratio.neg ? (i_ratio.base - vdq_pkg::DIR_W'(offset))
                                  : (i_ratio.base + vdq_pkg::DIR_W'(offset));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_direction <= n_direction;
    end

    assign o_valid     = r_valid;
    assign o_direction = r_direction;

endmodule

@@ rtl/core/vector_direction_quantizer_unit.sv @@
// vector direction quantizer: source and target point in, 16-sector direction out
// depends on vdq_pkg, vdq_delta, vdq_octant, vdq_sector
//
// usage
//   command channel: drive i_from_x, i_from_y, i_to_x, i_to_y and raise start;
//   a transfer happens at each rising edge with start high and busy low.
//   busy is held low, so a new command may be given in every cycle.
//   result channel: o_direction is valid for one cycle while o_valid is high
//   and is taken at the edge that ends that cycle. results come out in
//   command order, one per command.
// stages and throughput
//   three register stages (differences, octant and thresholds, offset);
//   each stage registers the command in turn on its way to o_direction.
//   one command per cycle sustained; the ratio minor / (major / 16) is
//   resolved by two constant-multiple compares in the last stage.
// reset
//   i_rst_n low clears every stage valid bit; commands in flight are dropped.
//   the receiver cannot stall, so no result is ever held back.

module vector_direction_quantizer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [vdq_pkg::COORD_W-1:0] i_from_x,
    input  logic [vdq_pkg::COORD_W-1:0] i_from_y,
    input  logic [vdq_pkg::COORD_W-1:0] i_to_x,
    input  logic [vdq_pkg::COORD_W-1:0] i_to_y,
    output logic                        o_valid,
    output logic [vdq_pkg::DIR_W-1:0]   o_direction
);

    logic             delta_valid;
    vdq_pkg::t_delta  delta;
    logic             ratio_valid;
    vdq_pkg::t_ratio  ratio;

    assign busy = 1'b0;

    vdq_delta u_delta (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & ~busy),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .o_valid  (delta_valid),
        .o_delta  (delta)
    );

    vdq_octant u_octant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (delta_valid),
        .i_delta (delta),
        .o_valid (ratio_valid),
        .o_ratio (ratio)
    );

    vdq_sector u_sector (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (ratio_valid),
        .i_ratio     (ratio),
        .o_valid     (o_valid),
        .o_direction (o_direction)
    );

endmodule

@@ rtl/core/vdq_checker.sv @@
// port-level checks for vector_direction_quantizer_unit, bound to the top level
// depends on vdq_pkg

module vdq_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [vdq_pkg::COORD_W-1:0] i_from_x,
    input  logic [vdq_pkg::COORD_W-1:0] i_from_y,
    input  logic [vdq_pkg::COORD_W-1:0] i_to_x,
    input  logic [vdq_pkg::COORD_W-1:0] i_to_y,
    input  logic                        o_valid,
    input  logic [vdq_pkg::DIR_W-1:0]   o_direction
);

    // every transfer yields exactly one result, and no result comes without a transfer
    a_latency_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result missing three cycles after transfer");

    a_latency_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##3 !o_valid)
        else $error("result without a matching transfer");

    // zero vector falls into the vertical case and points up
    a_zero_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_from_x == i_to_x && i_from_y == i_to_y)
        |-> ##3 (o_direction == vdq_pkg::DIR_UP))
        else $error("zero vector not reported as up");

    // same column always gives a vertical sector
    a_vertical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_from_x == i_to_x)
        |-> ##3 (o_direction == vdq_pkg::DIR_UP || o_direction == vdq_pkg::DIR_DOWN))
        else $error("vertical vector gave a non-vertical sector");

endmodule

bind vector_direction_quantizer_unit vdq_checker u_vdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_from_x    (i_from_x),
    .i_from_y    (i_from_y),
    .i_to_x      (i_to_x),
    .i_to_y      (i_to_y),
    .o_valid     (o_valid),
    .o_direction (o_direction)
);

@@ tb/tb_vector_direction_quantizer_unit.sv @@
// testbench for vector_direction_quantizer_unit: directed and random point pairs,
// every direction checked against a local sector predictor
// depends on vdq_pkg and the rtl/core sources
`timescale 1ns / 1ps

module tb_vector_direction_quantizer_unit;
    import vdq_pkg::*;

    localparam int RANDOM_PAIRS = 750;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;

    // octant offset by quotient minor / (major / 16), saturated at the last entry
    localparam logic [DIR_W-1:0] OCTANT_STEP [0:16] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2
    };

    typedef struct packed {
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
    } point_pair_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [COORD_W-1:0] i_from_x;
    logic [COORD_W-1:0] i_from_y;
    logic [COORD_W-1:0] i_to_x;
    logic [COORD_W-1:0] i_to_y;
    logic               o_valid;
    logic [DIR_W-1:0]   o_direction;

    point_pair_t      pair_queue[$];
    logic [DIR_W-1:0] sector_queue[$];
    logic             xfer_seen;
    int               burst_left;
    int               gap_left;
    int               pair_total;
    int               directed_total;
    int               accepted_cnt;
    int               checked_cnt;
    int               err_cnt;
    int               cycle_cnt;
    logic [15:0]      sectors_seen;

    vector_direction_quantizer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_from_x    (i_from_x),
        .i_from_y    (i_from_y),
        .i_to_x      (i_to_x),
        .i_to_y      (i_to_y),
        .o_valid     (o_valid),
        .o_direction (o_direction)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [DIR_W-1:0] octant_offset(int minor, int major);
        int q;
        q = minor / (major / 16);
        if (q > 16) q = 16;
        return OCTANT_STEP[q];
    endfunction

    function automatic logic [DIR_W-1:0] predict_sector(point_pair_t p);
        int dx, dy, ax, ay;
        dx = int'(p.to_x) - int'(p.from_x);
        dy = int'(p.to_y) - int'(p.from_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax <= int'(NEAR_LIMIT)) return (dy > 0) ? DIR_DOWN : DIR_UP;
        if (ay <= int'(NEAR_LIMIT)) return (dx > 0) ? DIR_RIGHT : DIR_LEFT;
        // on a diagonal tie x is the major axis
        if (dx > 0) begin
            if (dy < 0) begin
                if (ay > ax) return DIR_UP + octant_offset(ax, ay);
                return DIR_RIGHT - octant_offset(ay, ax);
            end
            if (ay > ax) return DIR_DOWN - octant_offset(ax, ay);
            return DIR_RIGHT + octant_offset(ay, ax);
        end
        if (dy > 0) begin
            if (ay > ax) return DIR_DOWN + octant_offset(ax, ay);
            return DIR_LEFT - octant_offset(ay, ax);
        end
        if (ay > ax) return DIR_UP - octant_offset(ax, ay);
        return DIR_LEFT + octant_offset(ay, ax);
    endfunction

    // source coordinate that keeps source + delta inside the coordinate range
    function automatic int pick_origin(int d);
        if (d >= 0) return int'($urandom_range(0, 1023 - d));
        return int'($urandom_range(-d, 1023));
    endfunction

    task automatic add_pair(int fx, int fy, int tx, int ty);
        point_pair_t p;
        p.from_x = COORD_W'(fx);
        p.from_y = COORD_W'(fy);
        p.to_x   = COORD_W'(tx);
        p.to_y   = COORD_W'(ty);
        pair_queue.push_back(p);
    endtask

    // driver: bursts of commands separated by random gaps, noise on the data while idle
    always @(negedge i_clk) begin : cmd_driver
        logic        next_start;
        point_pair_t p;
        next_start = 1'b0;
        if (i_rst_n) begin
            if (start && !xfer_seen) begin
                next_start = 1'b1;   // not taken yet, hold
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pair_queue.size() > 0) begin
                p = pair_queue.pop_front();
                i_from_x   <= p.from_x;
                i_from_y   <= p.from_y;
                i_to_x     <= p.to_x;
                i_to_y     <= p.to_y;
                next_start = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                              : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        if (!next_start) begin
            i_from_x <= COORD_W'($urandom);
            i_from_y <= COORD_W'($urandom);
            i_to_x   <= COORD_W'($urandom);
            i_to_y   <= COORD_W'($urandom);
        end
        start <= next_start;
    end

    // monitor: check each result, then record the expectation of a command transfer
    always @(posedge i_clk) begin : result_monitor
        logic [DIR_W-1:0] want;
        point_pair_t      p;
        xfer_seen <= i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            if (sector_queue.size() == 0) begin
                $error("unexpected result: direction %0d with nothing pending", o_direction);
                err_cnt++;
            end else begin
                want = sector_queue.pop_front();
                checked_cnt++;
                if (o_direction !== want) begin
                    $error("direction mismatch: expected %0d, actual %0d", want, o_direction);
                    err_cnt++;
                end else begin
                    sectors_seen[want] = 1'b1;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            p.from_x = i_from_x;
            p.from_y = i_from_y;
            p.to_x   = i_to_x;
            p.to_y   = i_to_y;
            sector_queue.push_back(predict_sector(p));
            accepted_cnt++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d commands taken",
                     cycle_cnt, accepted_cnt, pair_total);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int mode, ddx, ddy, major, minor, k, n;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_from_x     = '0;
        i_from_y     = '0;
        i_to_x       = '0;
        i_to_y       = '0;
        xfer_seen    = 1'b0;
        burst_left   = 1;
        gap_left     = 0;
        accepted_cnt = 0;
        checked_cnt  = 0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        sectors_seen = '0;

        // zero vectors
        add_pair(100, 100, 100, 100);
        add_pair(1023, 1023, 1023, 1023);
        // corner to corner, diagonal ties in all four quadrants
        add_pair(0, 0, 1023, 1023);
        add_pair(1023, 1023, 0, 0);
        add_pair(0, 1023, 1023, 0);
        add_pair(1023, 0, 0, 1023);
        // pure axes at full length
        add_pair(0, 0, 1023, 0);
        add_pair(1023, 0, 0, 0);
        add_pair(0, 0, 0, 1023);
        add_pair(0, 1023, 0, 0);
        // near-axis limits on x then y
        add_pair(500, 500, 531, 900);
        add_pair(500, 500, 469, 100);
        add_pair(500, 500, 532, 900);
        add_pair(500, 500, 900, 531);
        add_pair(500, 500, 100, 469);
        add_pair(500, 500, 900, 532);
        // quotient above the table, saturates
        add_pair(500, 500, 547, 547);
        add_pair(500, 500, 453, 540);
        // quotient on each side of the offset steps
        add_pair(0, 0, 512, 127);
        add_pair(0, 0, 512, 128);
        add_pair(0, 0, 512, 383);
        add_pair(0, 0, 512, 384);
        add_pair(600, 600, 472, 88);
        add_pair(100, 100, 483, 612);
        directed_total = pair_queue.size();

        for (n = 0; n < RANDOM_PAIRS; n++) begin
            mode = $urandom_range(0, 4);
            case (mode)
                0: begin
                    ddx = int'($urandom_range(0, 2046)) - 1023;
                    ddy = int'($urandom_range(0, 2046)) - 1023;
                end
                1: begin
                    // one difference around the near-axis limit
                    ddx = $urandom_range(0, 40);
                    ddy = int'($urandom_range(0, 2046)) - 1023;
                    if ($urandom_range(0, 1)) ddx = -ddx;
                    if ($urandom_range(0, 1)) begin
                        k = ddx; ddx = ddy; ddy = k;
                    end
                end
                2: begin
                    // close to a diagonal
                    ddx = $urandom_range(32, 1023);
                    ddy = ddx + int'($urandom_range(0, 6)) - 3;
                    if (ddy > 1023) ddy = 1023;
                    if ($urandom_range(0, 1)) ddx = -ddx;
                    if ($urandom_range(0, 1)) ddy = -ddy;
                end
                3: begin
                    // short vectors where the quotient can run past the table end
                    ddx = $urandom_range(32, 80);
                    ddy = $urandom_range(32, 80);
                    if ($urandom_range(0, 1)) ddx = -ddx;
                    if ($urandom_range(0, 1)) ddy = -ddy;
                end
                default: begin
                    // minor axis just around an offset step
                    major = $urandom_range(32, 1023);
                    k     = $urandom_range(0, 1) ? 4 : 12;
                    minor = k * (major / 16) + int'($urandom_range(0, 2)) - 1;
                    if (minor < 32) minor = 32;
                    if (minor > major) minor = major;
                    ddx = major;
                    ddy = minor;
                    if ($urandom_range(0, 1)) begin
                        ddx = minor; ddy = major;
                    end
                    if ($urandom_range(0, 1)) ddx = -ddx;
                    if ($urandom_range(0, 1)) ddy = -ddy;
                end
            endcase
            if (mode == 0 && $urandom_range(0, 1)) begin
                add_pair($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 1023));
            end else begin
                k     = pick_origin(ddx);
                major = pick_origin(ddy);
                add_pair(k, major, k + ddx, major + ddy);
            end
        end
        pair_total = pair_queue.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < pair_total) @(posedge i_clk);
        while (sector_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sector_queue.size() > 0) begin
            $error("%0d directions never came out", sector_queue.size());
            err_cnt++;
        end
        $display("%0d commands (%0d directed), %0d directions checked, %0d errors",
                 accepted_cnt, directed_total, checked_cnt, err_cnt);
        $display("sectors confirmed: %016b", sectors_seen);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/vdq_pkg.sv
rtl/core/vdq_delta.sv
rtl/core/vdq_octant.sv
rtl/core/vdq_sector.sv
rtl/core/vector_direction_quantizer_unit.sv
rtl/core/vdq_checker.sv
tb/tb_vector_direction_quantizer_unit.sv
